FILE: src/base32_stream_encoder_unit_macros.svh
// Assertion macros used by the RTL of the base32 stream encoder.
// Each macro checks a property on the rising edge of clock, disabled in reset.
`ifndef BASE32_STREAM_ENCODER_UNIT_MACROS_SVH
`define BASE32_STREAM_ENCODER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define B32ENC_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define B32ENC_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define B32ENC_ASSERT_IMP(lbl, ante, cons, msg)
`define B32ENC_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

FILE: src/b32enc_pkg.sv
`timescale 1ns / 1ps

package b32enc_pkg;

   localparam int unsigned MaxCharsWidth = 10;
   localparam int unsigned CsrDataWidth = 32;
   localparam int unsigned CsrAddrWidth = 3;
   localparam int unsigned MaxResults = 3;

   localparam logic [MaxCharsWidth-1:0] MaxCharsReset = 10'd1023;
   localparam logic [CsrAddrWidth-1:0] AddrMaxChars = 3'd0;

   // Base32 alphabet with the digit two replaced by nine.
   localparam logic [6:0] SymTable [32] = '{
      7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46, 7'h47, 7'h48,
      7'h49, 7'h4A, 7'h4B, 7'h4C, 7'h4D, 7'h4E, 7'h4F, 7'h50,
      7'h51, 7'h52, 7'h53, 7'h54, 7'h55, 7'h56, 7'h57, 7'h58,
      7'h59, 7'h5A, 7'h39, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37
   };

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_payload_type;

   typedef struct packed {
      logic [6:0] character;
      logic       overflow;
      logic       last_char;
   } rsp_payload_type;

   // Per-message encoder state. Only the pending bits of the buffer are kept.
   typedef struct packed {
      logic [3:0]               bit_buffer;
      logic [2:0]               pending_bits;
      logic [MaxCharsWidth-1:0] chars_written;
      logic                     failed;
   } enc_state_type;

endpackage

FILE: src/b32enc_step.sv
`timescale 1ns / 1ps

// Works out all results of one byte and the state that follows it.
module b32enc_step import b32enc_pkg::*; (
   input  enc_state_type            state,
   input  req_payload_type          item,
   input  logic [MaxCharsWidth-1:0] max_chars,
   output rsp_payload_type          results [MaxResults],
   output logic [1:0]               count,
   output enc_state_type            next_state
);

   logic [11:0] buf12;
   logic [11:0] rem_bits;
   logic [3:0]  total;
   logic [3:0]  shift0;
   logic [3:0]  shift1;
   logic [3:0]  rem_cnt;
   logic        two;
   logic        has_flush;
   logic [1:0]  m_cnt;
   logic [4:0]  syms [MaxResults];
   logic [MaxResults-1:0] fail;
   logic        ovf;

   always_comb begin
      buf12 = {state.bit_buffer, item.data_byte};
      total = {1'b0, state.pending_bits} + 4'd8;
      two = (total >= 4'd10);
      shift0 = total - 4'd5;
      shift1 = total - 4'd10;
      rem_cnt = two ? shift1 : shift0;
      rem_bits = buf12 & ((12'd1 << rem_cnt) - 12'd1);
      has_flush = item.last_byte && (rem_cnt != 4'd0);
      m_cnt = 2'd1 + {1'b0, two} + {1'b0, has_flush};

      syms[0] = 5'(buf12 >> shift0);
      syms[2] = 5'(rem_bits << (4'd5 - rem_cnt));
      syms[1] = two ? 5'(buf12 >> shift1) : syms[2];

      // Result j is allowed only while chars_written + j + 1 is below the limit.
      for (int j = 0; j < MaxResults; j++) begin
         fail[j] = ({2'b00, state.chars_written} + 12'(j + 1)) >= {2'b00, max_chars};
         results[j].character = fail[j] ? 7'd0 : SymTable[syms[j]];
         results[j].overflow = fail[j];
         results[j].last_char = fail[j] || (item.last_byte && (2'(j) == m_cnt - 2'd1));
      end

      ovf = fail[0] || ((m_cnt >= 2'd2) && fail[1]) || ((m_cnt == 2'd3) && fail[2]);

      if (fail[0]) begin
         count = 2'd1;
      end else if ((m_cnt >= 2'd2) && fail[1]) begin
         count = 2'd2;
      end else if ((m_cnt == 2'd3) && fail[2]) begin
         count = 2'd3;
      end else begin
         count = m_cnt;
      end

      next_state = state;
      if (state.failed) begin
         count = 2'd0;
         if (item.last_byte) begin
            next_state = '0;
         end
      end else if (item.last_byte) begin
         next_state = '0;
      end else if (ovf) begin
         next_state.failed = 1'b1;
         next_state.bit_buffer = 4'd0;
         next_state.pending_bits = 3'd0;
      end else begin
         next_state.bit_buffer = rem_bits[3:0];
         next_state.pending_bits = rem_cnt[2:0];
         next_state.chars_written = state.chars_written + (two ? 10'd2 : 10'd1);
      end
   end

endmodule

FILE: src/base32_stream_encoder_unit.sv
`timescale 1ns / 1ps
// A byte's first character is registered into the result register once the byte is in the
// input register and the result register can take a beat. The byte stays there until all its
// results have left; the single result register drains one beat per cycle unless rsp stalls.
// A new byte is taken in the same cycle that the previous byte hands over its final result.
// Reset (synchronous, active high) empties both registers, clears the message state and
// returns max_chars to 1023.

`include "base32_stream_encoder_unit_macros.svh"

module base32_stream_encoder_unit import b32enc_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,

   input  logic                    req_valid,
   output logic                    req_ready,
   input  req_payload_type         req_payload,

   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output rsp_payload_type         rsp_payload,

   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [CsrAddrWidth-1:0] paddr,
   input  logic [CsrDataWidth-1:0] pwdata,
   output logic [CsrDataWidth-1:0] prdata,
   output logic                    pready
);

   // The input register holds the byte being worked on. Its results are computed in one
   // combinational pass from the byte and the message state, and are moved into the result
   // register one beat per cycle while it can take one, selected by the result index.
   logic                     in_valid_ff, in_valid_in;
   req_payload_type          in_data_ff, in_data_in;
   logic [1:0]               idx_ff, idx_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_payload_type          rsp_data_ff, rsp_data_in;
   enc_state_type            state_ff, state_in;
   logic [MaxCharsWidth-1:0] max_chars_ff, max_chars_in;

   rsp_payload_type results [MaxResults];
   logic [1:0]      count;
   enc_state_type   step_state;
   logic            load_ok;
   logic            item_done;
   logic            csr_write;

   b32enc_step u_step (
      .state      (state_ff),
      .item       (in_data_ff),
      .max_chars  (max_chars_ff),
      .results    (results),
      .count      (count),
      .next_state (step_state)
   );

   // The result register can take a new beat when it is empty or being drained now.
   assign load_ok = !rsp_valid_ff || rsp_ready;

   // The held byte is done when its last result moves out; with none, when load_ok holds.
   assign item_done = in_valid_ff && load_ok &&
                      ((count == 2'd0) || (idx_ff == count - 2'd1));

   assign req_ready = !in_valid_ff || item_done;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_data_in = in_data_ff;
      idx_in = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      state_in = state_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (in_valid_ff && load_ok && (count != 2'd0)) begin
         rsp_valid_in = 1'b1;
         rsp_data_in = results[idx_ff];
         idx_in = idx_ff + 2'd1;
      end

      // The state moves on only once every result of the byte has left.
      if (item_done) begin
         in_valid_in = 1'b0;
         idx_in = 2'd0;
         state_in = step_state;
      end

      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_data_in = req_payload;
      end
   end

   // The configuration port has one register, max_chars, at byte address zero.
   assign csr_write = psel && penable && pwrite;
   assign pready = 1'b1;

   always_comb begin
      max_chars_in = max_chars_ff;
      if (csr_write && (paddr == AddrMaxChars)) begin
         max_chars_in = pwdata[MaxCharsWidth-1:0];
      end
   end

   assign prdata = (paddr == AddrMaxChars) ?
                   {{(CsrDataWidth-MaxCharsWidth){1'b0}}, max_chars_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         idx_ff <= 2'd0;
         rsp_valid_ff <= 1'b0;
         state_ff <= '0;
         max_chars_ff <= MaxCharsReset;
      end else begin
         in_valid_ff <= in_valid_in;
         idx_ff <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff <= state_in;
         max_chars_ff <= max_chars_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      in_data_ff <= in_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   // An overflow beat always closes the message.
   `B32ENC_ASSERT_IMP(a_ovf_is_last, rsp_valid_ff && rsp_data_ff.overflow,
                      rsp_data_ff.last_char, "overflow beat without last_char")
   // At most four bits ever wait in the buffer between bytes.
   `B32ENC_ASSERT_IMP(a_pending_range, 1'b1, state_ff.pending_bits <= 3'd4,
                      "pending bit count out of range")
   // The result index never runs past the results of the held byte.
   `B32ENC_ASSERT_IMP(a_idx_range, in_valid_ff && (idx_ff != 2'd0), idx_ff < count,
                      "result index beyond result count")
   // A failed message yields no beats.
   `B32ENC_ASSERT_IMP(a_failed_silent, in_valid_ff && state_ff.failed, count == 2'd0,
                      "results produced after overflow")
   // Finishing the last byte of a message clears the message state.
   `B32ENC_ASSERT_NXT(a_last_clears, item_done && in_data_ff.last_byte,
                      (state_ff == '0), "message state not cleared after last byte")

endmodule

FILE: tb/base32_char_checker.sv
`timescale 1ns / 1ps

// Watches the byte and character channels and the register port of the encoder,
// keeps its own model of the encoding state and checks every character beat
// against the oldest predicted one.
module base32_char_checker import b32enc_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_ready,
   input  req_payload_type         req_payload,
   input  logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  rsp_payload_type         rsp_payload,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic                    pready,
   input  logic [CsrAddrWidth-1:0] paddr,
   input  logic [CsrDataWidth-1:0] pwdata,
   output int                      outstanding,
   output int                      mismatches
);

   localparam logic [6:0] AsciiUpperA = 7'h41;
   localparam logic [6:0] AsciiThree  = 7'h33;
   localparam logic [6:0] AsciiNine   = 7'h39;

   rsp_payload_type          expected_chars[$];
   logic [11:0]              bit_buf;
   int unsigned              pend_bits;
   logic [MaxCharsWidth-1:0] chars_sent;
   logic                     msg_failed;
   logic [MaxCharsWidth-1:0] char_limit;
   int                       error_total;

   initial begin
      outstanding = 0;
      mismatches  = 0;
      error_total = 0;
   end

   function automatic void start_new_message();
      bit_buf    = '0;
      pend_bits  = 0;
      chars_sent = '0;
      msg_failed = 1'b0;
   endfunction

   // Queues one character, or the overflow beat once the limit is hit.
   function automatic bit emit_char(input logic [4:0] sym);
      rsp_payload_type beat;
      logic [6:0]      ch;
      if (int'(chars_sent) + 1 >= int'(char_limit)) begin
         beat = '{character: 7'd0, overflow: 1'b1, last_char: 1'b1};
         expected_chars.push_back(beat);
         msg_failed = 1'b1;
         return 1'b0;
      end
      if (sym < 5'd26) begin
         ch = AsciiUpperA + 7'(sym);
      end else if (sym == 5'd26) begin
         // The alphabet's digit two goes out as a nine.
         ch = AsciiNine;
      end else begin
         ch = AsciiThree + 7'(sym - 5'd27);
      end
      beat = '{character: ch, overflow: 1'b0, last_char: 1'b0};
      expected_chars.push_back(beat);
      chars_sent = chars_sent + 1'b1;
      return 1'b1;
   endfunction

   task automatic predict_byte(input req_payload_type item);
      bit              ok;
      int              size_before;
      rsp_payload_type tail;
      ok = 1'b1;
      size_before = expected_chars.size();
      if (msg_failed) begin
         if (item.last_byte) start_new_message();
         return;
      end
      bit_buf = {bit_buf[3:0], item.data_byte};
      pend_bits += 8;
      while (ok && pend_bits >= 5) begin
         pend_bits -= 5;
         ok = emit_char(5'((bit_buf >> pend_bits) & 12'h01F));
      end
      if (ok) bit_buf = bit_buf & ((12'd1 << pend_bits) - 12'd1);
      if (ok && item.last_byte && pend_bits > 0) begin
         ok = emit_char(5'((bit_buf << (5 - pend_bits)) & 12'h01F));
      end
      if (item.last_byte || !ok) begin
         if (ok && expected_chars.size() > size_before) begin
            tail = expected_chars.pop_back();
            tail.last_char = 1'b1;
            expected_chars.push_back(tail);
         end
         if (item.last_byte) begin
            start_new_message();
         end else begin
            bit_buf   = '0;
            pend_bits = 0;
         end
      end
   endtask

   task automatic check_char(input rsp_payload_type got);
      rsp_payload_type want;
      if (expected_chars.size() == 0) begin
         $error("unexpected character beat %h", got);
         error_total++;
         return;
      end
      want = expected_chars.pop_front();
      if (got.character !== want.character) begin
         $error("character: expected %h, got %h", want.character, got.character);
         error_total++;
      end
      if (got.overflow !== want.overflow) begin
         $error("overflow: expected %b, got %b", want.overflow, got.overflow);
         error_total++;
      end
      if (got.last_char !== want.last_char) begin
         $error("last_char: expected %b, got %b", want.last_char, got.last_char);
         error_total++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         char_limit = MaxCharsReset;
         start_new_message();
         expected_chars.delete();
      end else begin
         if (rsp_valid && rsp_ready) check_char(rsp_payload);
         if (psel && penable && pwrite && pready && paddr == AddrMaxChars) begin
            char_limit = pwdata[MaxCharsWidth-1:0];
         end
         if (req_valid && req_ready) predict_byte(req_payload);
      end
      outstanding <= expected_chars.size();
      mismatches  <= error_total;
   end

endmodule

FILE: tb/base32_stream_encoder_unit_tb.sv
`timescale 1ns / 1ps

// Top of the encoder bench. It only makes stimulus and calls the verdict; all
// prediction and comparison live in the checker instantiated next to the block.
module base32_stream_encoder_unit_tb import b32enc_pkg::*; ();

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   req_payload_type         req_payload;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   rsp_payload_type         rsp_payload;
   logic                    psel;
   logic                    penable;
   logic                    pwrite;
   logic [CsrAddrWidth-1:0] paddr;
   logic [CsrDataWidth-1:0] pwdata;
   logic [CsrDataWidth-1:0] prdata;
   logic                    pready;

   // Percentages of cycles in which the sender holds back and the receiver stalls.
   int idle_pct  = 0;
   int stall_pct = 0;

   int outstanding;
   int mismatches;

   base32_stream_encoder_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   base32_char_checker char_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .pready      (pready),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .outstanding (outstanding),
      .mismatches  (mismatches)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Hard stop. A correct run needs only a small fraction of this time, even
   // with every byte giving three characters that each sit out long stalls.
   initial begin
      #400000;
      $display("end of test: mismatches");
      $finish;
   end

   // The receiver decides afresh every cycle whether it takes a beat. It is held
   // off during reset so that no beat can slip through before the checker is live.
   always @(posedge clock) begin
      rsp_ready <= reset ? 1'b0 : ($urandom_range(99) >= stall_pct);
   end

   // Offers one byte beat and returns at the edge where it was taken. The sender
   // idles before the beat, cycle by cycle, with the current idle percentage.
   // Valid is only dropped when an idle cycle is actually inserted, so a run of
   // back-to-back beats keeps it high without a glitch.
   task automatic send_beat(input logic [7:0] data, input logic is_last);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{data_byte: data, last_byte: is_last};
      do @(posedge clock); while (!req_ready);
   endtask

   // Lets the block drain. The checker's count of outstanding beats is registered,
   // hence the first wait. Bytes after an overflow give nothing back, so an extra
   // wait follows before anything touches the register.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Setup cycle, then access cycle; the register takes the value at the edge
   // that closes the access cycle.
   task automatic write_max_chars(input int unsigned value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= AddrMaxChars;
      pwdata  <= CsrDataWidth'(value);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Random bytes with a bias toward all zeros and all ones; roughly one byte in
   // six closes its message, so messages vary in length and some stay open
   // across a phase boundary.
   task automatic send_random(input int count);
      logic [7:0] data;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(7))
            0: data = 8'h00;
            1: data = 8'hFF;
            default: data = 8'($urandom_range(255));
         endcase
         send_beat(data, $urandom_range(5) == 0);
      end
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      psel        = 1'b0;
      penable     = 1'b0;
      pwrite      = 1'b0;
      paddr       = '0;
      pwdata      = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, no idling on either side.
      write_max_chars(1023);
      // A lone zero byte: one character plus a flushed one from three leftover bits.
      send_beat(8'h00, 1'b1);
      send_beat(8'hFF, 1'b1);
      // Leading group 11010 is the symbol printed as a nine.
      send_beat(8'hD0, 1'b1);
      // Forty bits split evenly into eight characters, so nothing is flushed.
      send_beat(8'h68, 1'b0);
      send_beat(8'h65, 1'b0);
      send_beat(8'h6C, 1'b0);
      send_beat(8'h6C, 1'b0);
      send_beat(8'h6F, 1'b1);
      send_beat(8'h55, 1'b0);
      send_beat(8'hAA, 1'b1);
      drain();

      // A limit of one overflows on the very first character. The bytes after
      // that are swallowed, including the closing one.
      write_max_chars(1);
      send_beat(8'h12, 1'b0);
      send_beat(8'h34, 1'b0);
      send_beat(8'h56, 1'b1);
      drain();

      // A limit of zero behaves the same, here on a single closing byte.
      write_max_chars(0);
      send_beat(8'hFF, 1'b1);
      drain();

      // With a limit of three the second byte gives one character and then the
      // overflow beat in the same step.
      write_max_chars(3);
      send_beat(8'h00, 1'b0);
      send_beat(8'h00, 1'b1);
      drain();

      // Here the overflow falls on the flushed character.
      write_max_chars(2);
      send_beat(8'hF0, 1'b1);
      drain();

      // Shrink the limit while a message is open: three characters are out, so
      // the next one must overflow.
      write_max_chars(1023);
      send_beat(8'hAB, 1'b0);
      send_beat(8'hCD, 1'b0);
      drain();
      write_max_chars(4);
      send_beat(8'hEF, 1'b1);
      drain();

      // Random part. Each phase sets the limit, most also the idle mix; the drain
      // between phases is where the sender waits for every beat to come back.
      write_max_chars(1023);
      send_random(50);
      drain();

      idle_pct = 78;
      write_max_chars($urandom_range(12, 2));
      send_random(50);
      drain();

      idle_pct  = 0;
      stall_pct = 78;
      write_max_chars($urandom_range(60, 13));
      send_random(50);
      drain();

      idle_pct  = 17;
      stall_pct = 17;
      write_max_chars(1023);
      send_random(50);
      drain();

      idle_pct  = 0;
      stall_pct = 0;
      write_max_chars($urandom_range(2, 0));
      send_random(50);
      drain();

      if (mismatches == 0 && outstanding == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
